/* design/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg: array list engine package
// Shared types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned POS_W    = 6;

  typedef enum logic [KIND_W-1:0] {
    K_INS_TAIL   = 3'd0,
    K_INS_HEAD   = 3'd1,
    K_INS_AFTER  = 3'd2,
    K_INS_BEFORE = 3'd3,
    K_DEL_TAIL   = 3'd4,
    K_DEL_HEAD   = 3'd5,
    K_DEL_VALUE  = 3'd6,
    K_DUMP       = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NOKEY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DUMP,
    S_EMIT
  } state_e;

endpackage

/* design/array_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// array_list_engine_unit: ordered list engine
// Keeps an ordered list of words in a RAM and runs insert, delete, search and
// dump one element per cycle under a small sequencer, dump only when unstalled.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid_i / in_stall_o   kind_i, value_i, key_i
//  out      output     out_valid_o / out_stall_i status_o, count_o, position_o,
//                                                data_o, last_o
//
//  After acceptance the block is busy until its result is emitted. A keyed insert
//  or a delete by value first searches for the key and then shifts the elements
//  behind its position; search and shift together pass over the list once. A
//  dump gives one result per cycle while the output is not stalled.
//  No clearing pass follows reset; the list is empty once reset is released.
//  A stalled output holds the sequencer only when it has a new result to load.
// ----------------------------------------------------------------------------
module array_list_engine_unit #(
  parameter int unsigned CAPACITY   = ale_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ale_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [ale_pkg::WORD_W-1:0]   value_i,
  input  logic signed [ale_pkg::WORD_W-1:0]   key_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ale_pkg::STATUS_W-1:0]        status_o,
  output logic [ale_pkg::COUNT_W-1:0]         count_o,
  output logic [ale_pkg::POS_W-1:0]           position_o,
  output logic signed [ale_pkg::WORD_W-1:0]   data_o,
  output logic                                last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ale_pkg::state_e  state_q, state_d;
  ale_pkg::kind_e   kind_q, kind_d, in_kind;
  ale_pkg::status_e stat_q, stat_d;

  logic [DATA_WIDTH-1:0] target_q, target_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         mv_q, mv_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         wa_q, wa_d;
  logic                  wr_pend_q, wr_pend_d;
  logic                  chk_q, chk_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  in_acc;
  logic                  out_free;
  logic                  is_full;
  logic                  is_empty;
  logic [CW-1:0]         sp;

  logic                  ld;
  ale_pkg::status_e      ld_status;
  logic [AW-1:0]         ld_pos;
  logic [DATA_WIDTH-1:0] ld_data;
  logic                  ld_last;

  logic                  out_valid_q;
  ale_pkg::status_e      o_status_q;
  logic [CW-1:0]         o_count_q;
  logic [AW-1:0]         o_pos_q;
  logic [DATA_WIDTH-1:0] o_data_q;
  logic                  o_last_q;

  ale_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ale_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_full    = (count_q == CW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign in_kind    = ale_pkg::kind_e'(kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ale_pkg::S_IDLE;
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      chk_q       <= chk_d;
      out_valid_q <= ld || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    stat_q   <= stat_d;
    target_q <= target_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    mv_q     <= mv_d;
    pos_q    <= pos_d;
    wa_q     <= wa_d;
    if (ld) begin
      o_status_q <= ld_status;
      o_count_q  <= count_d;
      o_pos_q    <= ld_pos;
      o_data_q   <= ld_data;
      o_last_q   <= ld_last;
    end
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    stat_d    = stat_q;
    target_d  = target_q;
    val_d     = val_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    mv_d      = mv_q;
    pos_d     = pos_q;
    wa_d      = wa_q;
    wr_pend_d = wr_pend_q;
    chk_d     = chk_q;
    sp        = '0;
    ram_we    = 1'b0;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];
    ld        = 1'b0;
    ld_status = stat_q;
    ld_pos    = pos_q;
    ld_data   = '0;
    ld_last   = 1'b1;

    case (state_q)
      ale_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_d    = in_kind;
          val_d     = DATA_WIDTH'($unsigned(value_i));
          target_d  = DATA_WIDTH'($unsigned(key_i));
          wr_pend_d = 1'b0;
          chk_d     = 1'b0;
          stat_d    = ale_pkg::STAT_OK;
          pos_d     = '0;
          ptr_d     = '0;
          case (in_kind)
            ale_pkg::K_INS_TAIL, ale_pkg::K_INS_HEAD: begin
              if (is_full) begin
                stat_d  = ale_pkg::STAT_FULL;
                state_d = ale_pkg::S_EMIT;
              end else begin
                sp      = (in_kind == ale_pkg::K_INS_TAIL) ? count_q : '0;
                ptr_d   = count_q - CW'(1);
                mv_d    = count_q - sp;
                pos_d   = sp[AW-1:0];
                state_d = ale_pkg::S_SHIFT_UP;
              end
            end
            ale_pkg::K_INS_AFTER, ale_pkg::K_INS_BEFORE: begin
              if (is_full) begin
                stat_d  = ale_pkg::STAT_FULL;
                state_d = ale_pkg::S_EMIT;
              end else if (is_empty) begin
                stat_d  = ale_pkg::STAT_NOKEY;
                state_d = ale_pkg::S_EMIT;
              end else begin
                state_d = ale_pkg::S_SEARCH;
              end
            end
            ale_pkg::K_DEL_TAIL, ale_pkg::K_DEL_HEAD: begin
              if (is_empty) begin
                stat_d  = ale_pkg::STAT_EMPTY;
                state_d = ale_pkg::S_EMIT;
              end else begin
                sp      = (in_kind == ale_pkg::K_DEL_TAIL) ? (count_q - CW'(1)) : '0;
                ptr_d   = sp + CW'(1);
                mv_d    = count_q - CW'(1) - sp;
                pos_d   = sp[AW-1:0];
                state_d = ale_pkg::S_SHIFT_DN;
              end
            end
            ale_pkg::K_DEL_VALUE: begin
              target_d = DATA_WIDTH'($unsigned(value_i));
              if (is_empty) begin
                stat_d  = ale_pkg::STAT_EMPTY;
                state_d = ale_pkg::S_EMIT;
              end else begin
                state_d = ale_pkg::S_SEARCH;
              end
            end
            default: begin
              if (is_empty) begin
                stat_d  = ale_pkg::STAT_EMPTY;
                state_d = ale_pkg::S_EMIT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ale_pkg::S_DUMP;
              end
            end
          endcase
        end
      end

      ale_pkg::S_SEARCH: begin
        if (chk_q && (ram_rdata == target_q)) begin
          chk_d = 1'b0;
          if (kind_q == ale_pkg::K_INS_AFTER) begin
            sp = ptr_q;
          end else begin
            sp = ptr_q - CW'(1);
          end
          pos_d = sp[AW-1:0];
          if (kind_q == ale_pkg::K_DEL_VALUE) begin
            ptr_d   = sp + CW'(1);
            mv_d    = count_q - CW'(1) - sp;
            state_d = ale_pkg::S_SHIFT_DN;
          end else begin
            ptr_d   = count_q - CW'(1);
            mv_d    = count_q - sp;
            state_d = ale_pkg::S_SHIFT_UP;
          end
        end else if (ptr_q == count_q) begin
          chk_d   = 1'b0;
          stat_d  = ale_pkg::STAT_NOKEY;
          pos_d   = '0;
          state_d = ale_pkg::S_EMIT;
        end else begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CW'(1);
          chk_d  = 1'b1;
        end
      end

      ale_pkg::S_SHIFT_UP: begin
        ram_we = wr_pend_q;
        if (mv_q == '0) begin
          wr_pend_d = 1'b0;
          state_d   = ale_pkg::S_PUT;
        end else begin
          ram_re    = 1'b1;
          wa_d      = ptr_q[AW-1:0] + AW'(1);
          ptr_d     = ptr_q - CW'(1);
          mv_d      = mv_q - CW'(1);
          wr_pend_d = 1'b1;
        end
      end

      ale_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        stat_d    = ale_pkg::STAT_OK;
        state_d   = ale_pkg::S_EMIT;
      end

      ale_pkg::S_SHIFT_DN: begin
        ram_we = wr_pend_q;
        if (mv_q == '0) begin
          wr_pend_d = 1'b0;
          count_d   = count_q - CW'(1);
          stat_d    = ale_pkg::STAT_OK;
          state_d   = ale_pkg::S_EMIT;
        end else begin
          ram_re    = 1'b1;
          wa_d      = ptr_q[AW-1:0] - AW'(1);
          ptr_d     = ptr_q + CW'(1);
          mv_d      = mv_q - CW'(1);
          wr_pend_d = 1'b1;
        end
      end

      ale_pkg::S_DUMP: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = ale_pkg::STAT_OK;
          ld_pos    = ptr_q[AW-1:0];
          ld_data   = ram_rdata;
          ld_last   = (ptr_q == count_q - CW'(1));
          if (ld_last) begin
            state_d = ale_pkg::S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_q[AW-1:0] + AW'(1);
            ptr_d     = ptr_q + CW'(1);
          end
        end
      end

      ale_pkg::S_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          state_d = ale_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ale_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_status_q;
  assign count_o     = ale_pkg::COUNT_W'(o_count_q);
  assign position_o  = ale_pkg::POS_W'(o_pos_q);
  assign data_o      = ale_pkg::WORD_W'(o_data_q);
  assign last_o      = o_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ale_pkg::S_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && ld_last) |=> (state_q == ale_pkg::S_IDLE))
    else $error("sequencer busy after final result");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ale_pkg::S_PUT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list");

  a_check_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ale_pkg::S_SEARCH && chk_q) |-> (ptr_q != '0))
    else $error("search compare without a preceding read");

endmodule

/* design/ale_ram.sv */
// ----------------------------------------------------------------------------
// ale_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
